>>> rtl/core/ufbd_pkg.sv
// Package for the fractional baud divider search block.
// Widths, search limits and the sequencer state type; no dependencies.
package ufbd_pkg;

  localparam int unsigned ClockW    = 29;
  localparam int unsigned BaudW     = 24;
  localparam int unsigned DivW      = 16;
  localparam int unsigned FracW     = 4;
  localparam int unsigned ErrW      = 17;
  localparam int unsigned BaseShift = 6;
  localparam int unsigned BaseW     = ClockW - BaseShift;
  // dividend width covers mul * base
  localparam int unsigned DvdW      = FracW + BaseW;
  localparam int unsigned DsrW      = BaudW;
  localparam int unsigned BoundW    = 19;

  localparam logic [ClockW-1:0] ClockReset  = 29'd100000000;
  localparam logic [ErrW-1:0]   InitBestErr = 17'd100000;
  localparam logic [FracW-1:0]  FracMax     = 4'd15;
  localparam int unsigned       DivMin      = 3;
  localparam int unsigned       DivMax      = 65535;
  localparam int unsigned       AcceptPct   = 3;
  localparam int unsigned       PctScale    = 100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUND,
    ST_PAIR,
    ST_T,
    ST_D,
    ST_R,
    ST_STEP,
    ST_FINISH
  } state_e;

endpackage

>>> rtl/core/ufbd_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ufbd_pkg for default widths.
module ufbd_divider #(
  parameter int unsigned DvdW = ufbd_pkg::DvdW,
  parameter int unsigned DsrW = ufbd_pkg::DsrW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o,
  output logic [DsrW-1:0] remainder_o
);
  import ufbd_pkg::*;

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DsrW-1:0] rem_q, rem_d;
  logic [DsrW-1:0] dsr_q, dsr_d;
  logic [DsrW:0]   trial;
  logic [DsrW+1:0] diff;
  logic            ge;

  assign trial = {rem_q, quo_q[DvdW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};
  assign ge    = ~diff[DsrW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DvdW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      rem_d = ge ? diff[DsrW-1:0] : trial[DsrW-1:0];
      quo_d = {quo_q[DvdW-2:0], ge};
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/core/uart_fractional_baud_divider_search_top.sv
// Search: up to 240 multiplier and add pairs, with up to three divisions per pair on the one
// shared divider, after the 3 percent bound division; a zero rate runs no pair division, and
// the search ends after the first multiplier row when that row has no valid divisor.
// Throughput: one request per search; the next request is taken once back in idle,
// while the previous result may still wait in the output register.
// Reset: asynchronous, active low; clock register returns to 100 MHz, no result held.
module uart_fractional_baud_divider_search_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ufbd_pkg::ClockW-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ufbd_pkg::BaudW-1:0]     baud_rate_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           ok_o,
  output logic [ufbd_pkg::DivW-1:0]      divisor_o,
  output logic [ufbd_pkg::FracW-1:0]     mul_val_o,
  output logic [ufbd_pkg::FracW-1:0]     div_add_val_o,
  output logic [ufbd_pkg::ErrW-1:0]      best_error_o
);
  import ufbd_pkg::*;

  state_e state_q, state_d;

  logic [ClockW-1:0] clk_hz_q;
  logic [BaudW-1:0]  baud_q, baud_d;
  logic [BoundW-1:0] bound_q, bound_d;
  logic [DvdW-1:0]   t_q, t_d;
  logic [DivW-1:0]   d_q, d_d;
  logic [FracW-1:0]  m_q, m_d, a_q, a_d;
  logic [ErrW-1:0]   best_err_q, best_err_d;
  logic [FracW-1:0]  best_mul_q, best_mul_d, best_add_q, best_add_d;
  logic [DivW-1:0]   best_div_q, best_div_d;
  logic              last_zero_q, last_zero_d;

  logic              out_valid_q, out_valid_d;
  logic              ok_q, ok_d;
  logic [DivW-1:0]   divisor_q, divisor_d;
  logic [FracW-1:0]  mul_q, mul_d, add_q, add_d;
  logic [ErrW-1:0]   err_q, err_d;

  logic              div_start;
  logic [DvdW-1:0]   div_dvd;
  logic [DsrW-1:0]   div_dsr;
  logic              div_done;
  logic [DvdW-1:0]   div_quo;
  logic [DsrW-1:0]   div_rem;

  logic [BaseW-1:0]  base;
  logic [DvdW:0]     d_full;
  logic              d_valid;
  logic [DvdW-1:0]   baud_ext;
  logic [DvdW-1:0]   err_full;
  logic              err_better;
  logic              accept;

  ufbd_divider #(
    .DvdW (DvdW),
    .DsrW (DsrW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign base     = clk_hz_q[ClockW-1:BaseShift];
  assign baud_ext = DvdW'(baud_q);
  // round up when the remainder is above half the baud rate
  assign d_full   = {1'b0, div_quo} + (DvdW+1)'(div_rem > (baud_q >> 1));
  assign d_valid  = (d_full >= (DvdW+1)'(DivMin)) && (d_full <= (DvdW+1)'(DivMax));
  assign err_full = (div_quo <= baud_ext) ? (baud_ext - div_quo) : (div_quo - baud_ext);
  assign err_better = err_full < DvdW'(best_err_q);
  assign accept   = BoundW'(best_err_q) < bound_q;

  always_comb begin
    state_d     = state_q;
    baud_d      = baud_q;
    bound_d     = bound_q;
    t_d         = t_q;
    d_d         = d_q;
    m_d         = m_q;
    a_d         = a_q;
    best_err_d  = best_err_q;
    best_mul_d  = best_mul_q;
    best_add_d  = best_add_q;
    best_div_d  = best_div_q;
    last_zero_d = last_zero_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    ok_d        = ok_q;
    divisor_d   = divisor_q;
    mul_d       = mul_q;
    add_d       = add_q;
    err_d       = err_q;
    div_start   = 1'b0;
    div_dvd     = DvdW'(baud_rate_i) * DvdW'(AcceptPct);
    div_dsr     = DsrW'(PctScale);
    in_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          baud_d      = baud_rate_i;
          best_err_d  = InitBestErr;
          best_mul_d  = FracW'(1);
          best_add_d  = '0;
          best_div_d  = '0;
          last_zero_d = 1'b1;
          m_d         = FracW'(1);
          a_d         = '0;
          div_start   = 1'b1;
          state_d     = ST_BOUND;
        end
      end
      ST_BOUND: begin
        if (div_done) begin
          bound_d = div_quo[BoundW-1:0];
          state_d = ST_PAIR;
        end
      end
      ST_PAIR: begin
        // zero baud: every pair is invalid, no division
        if (baud_q == '0) begin
          state_d = ST_STEP;
        end else begin
          div_start = 1'b1;
          div_dvd   = DvdW'(m_q) * DvdW'(base);
          div_dsr   = DsrW'(m_q) + DsrW'(a_q);
          state_d   = ST_T;
        end
      end
      ST_T: begin
        if (div_done) begin
          t_d       = div_quo;
          div_start = 1'b1;
          div_dvd   = div_quo;
          div_dsr   = baud_q;
          state_d   = ST_D;
        end
      end
      ST_D: begin
        div_dvd = t_q;
        div_dsr = DsrW'(d_full[DivW-1:0]);
        if (div_done) begin
          if (d_valid) begin
            d_d       = d_full[DivW-1:0];
            div_start = 1'b1;
            state_d   = ST_R;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_R: begin
        if (div_done) begin
          last_zero_d = (err_full == '0);
          if (err_better) begin
            best_err_d = err_full[ErrW-1:0];
            best_mul_d = m_q;
            best_add_d = a_q;
            best_div_d = d_q;
          end
          if (err_full == '0) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (a_q == FracMax) begin
          if (last_zero_q || (m_q == FracMax)) begin
            state_d = ST_FINISH;
          end else begin
            m_d     = m_q + FracW'(1);
            a_d     = '0;
            state_d = ST_PAIR;
          end
        end else begin
          a_d     = a_q + FracW'(1);
          state_d = ST_PAIR;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ok_d        = accept;
          divisor_d   = accept ? best_div_q : '0;
          mul_d       = accept ? best_mul_q : '0;
          add_d       = accept ? best_add_q : '0;
          err_d       = accept ? best_err_q : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clk_hz_q    <= ClockReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        clk_hz_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    baud_q      <= baud_d;
    bound_q     <= bound_d;
    t_q         <= t_d;
    d_q         <= d_d;
    m_q         <= m_d;
    a_q         <= a_d;
    best_err_q  <= best_err_d;
    best_mul_q  <= best_mul_d;
    best_add_q  <= best_add_d;
    best_div_q  <= best_div_d;
    last_zero_q <= last_zero_d;
    ok_q        <= ok_d;
    divisor_q   <= divisor_d;
    mul_q       <= mul_d;
    add_q       <= add_d;
    err_q       <= err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign divisor_o     = divisor_q;
  assign mul_val_o     = mul_q;
  assign div_add_val_o = add_q;
  assign best_error_o  = err_q;

endmodule
